[design/gdfs_pkg.sv]
// Package for the depth-first preorder core: widths, result codes, microcode types
// and the control store that sequences the datapath.
// Depends on nothing; used by every module of the core.
`timescale 1ns / 1ps

package gdfs_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int VERTEX_W         = 6;
    localparam int ORDER_W          = 6;
    localparam int CFG_W            = 7;
    localparam int STATUS_W         = 2;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd64;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SELF_LOOP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef enum logic [3:0] {
        OP_LATCH,
        OP_INS_CHECK,
        OP_INS_TEST,
        OP_INS_SET_B,
        OP_EMIT_STATUS,
        OP_RUN_CLEAR,
        OP_VISIT_ROOT,
        OP_SCAN,
        OP_POP,
        OP_TOP_LOAD,
        OP_ROOT_INC,
        OP_EMIT_INIT,
        OP_EMIT_ENTRY,
        OP_NOP
    } uop_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_START,
        C_MODE_RUN,
        C_INS_BAD,
        C_EDGE_PRESENT,
        C_ROOT_END,
        C_ROOT_SEEN,
        C_CAND_NZ,
        C_LAST_POP,
        C_EMIT_MORE
    } cond_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_TEST,
        S_INS_SET_B,
        S_INS_EMIT,
        S_RUN_INIT,
        S_ROOT_CHK,
        S_ROOT_TEST,
        S_VISIT_ROOT,
        S_SCAN,
        S_POP,
        S_TOP_LOAD,
        S_ROOT_NEXT,
        S_EMIT_INIT,
        S_EMIT,
        S_EMIT_DONE
    } step_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic mode_run;
        logic ins_bad;
        logic edge_present;
        logic root_end;
        logic root_seen;
        logic cand_nz;
        logic last_pop;
        logic emit_more;
    } dp_flags_t;

    // When the condition holds the step jumps to its target, otherwise it falls through.
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            S_IDLE:       w = '{OP_LATCH,       C_NO_START,     S_IDLE};
            S_DISPATCH:   w = '{OP_NOP,         C_MODE_RUN,     S_RUN_INIT};
            S_INS_CHK:    w = '{OP_INS_CHECK,   C_INS_BAD,      S_INS_EMIT};
            S_INS_TEST:   w = '{OP_INS_TEST,    C_EDGE_PRESENT, S_INS_EMIT};
            S_INS_SET_B:  w = '{OP_INS_SET_B,   C_ALWAYS,       S_INS_EMIT};
            S_INS_EMIT:   w = '{OP_EMIT_STATUS, C_ALWAYS,       S_IDLE};
            S_RUN_INIT:   w = '{OP_RUN_CLEAR,   C_ALWAYS,       S_ROOT_CHK};
            S_ROOT_CHK:   w = '{OP_NOP,         C_ROOT_END,     S_EMIT_INIT};
            S_ROOT_TEST:  w = '{OP_NOP,         C_ROOT_SEEN,    S_ROOT_NEXT};
            S_VISIT_ROOT: w = '{OP_VISIT_ROOT,  C_ALWAYS,       S_SCAN};
            S_SCAN:       w = '{OP_SCAN,        C_CAND_NZ,      S_SCAN};
            S_POP:        w = '{OP_POP,         C_LAST_POP,     S_ROOT_NEXT};
            S_TOP_LOAD:   w = '{OP_TOP_LOAD,    C_ALWAYS,       S_SCAN};
            S_ROOT_NEXT:  w = '{OP_ROOT_INC,    C_ALWAYS,       S_ROOT_CHK};
            S_EMIT_INIT:  w = '{OP_EMIT_INIT,   C_ALWAYS,       S_EMIT};
            S_EMIT:       w = '{OP_EMIT_ENTRY,  C_EMIT_MORE,    S_EMIT};
            S_EMIT_DONE:  w = '{OP_NOP,         C_ALWAYS,       S_IDLE};
            default:      w = '{OP_NOP,         C_ALWAYS,       S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[design/graph_dfs_preorder_core.sv]
// Top level of the depth-first preorder core: joins the microcode sequencer
// and the datapath. Depends on gdfs_pkg, gdfs_sequencer and gdfs_datapath.
//
// Channel   Signals                                        Transfer
// command   start, busy, mode, vertex_a, vertex_b          start high while busy low
// config    cfg_valid, cfg_ready, cfg_data                 cfg_valid and cfg_ready high
// result    result_valid, kind, status, vertex,            one-cycle strobe, no stall
//           order_number, last
//
// An insert transaction gives one status result. A run transaction scans the
// roots and walks the graph with one adjacency row read per step, then gives
// one result per vertex. The adjacency matrix reads as empty right after
// reset through per-row valid bits. The receiver cannot stall; results leave
// on consecutive cycles.
`timescale 1ns / 1ps

module graph_dfs_preorder_core
#(
    parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [gdfs_pkg::VERTEX_W-1:0]     vertex_a,
    input  logic [gdfs_pkg::VERTEX_W-1:0]     vertex_b,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gdfs_pkg::CFG_W-1:0]        cfg_data,
    output logic                              result_valid,
    output logic                              kind,
    output logic [gdfs_pkg::STATUS_W-1:0]     status,
    output logic [gdfs_pkg::VERTEX_W-1:0]     vertex,
    output logic [gdfs_pkg::ORDER_W-1:0]      order_number,
    output logic                              last
);

    gdfs_pkg::ctrl_word_t ctrl;
    gdfs_pkg::dp_flags_t  flags;
    logic                 cfg_we;

    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    gdfs_sequencer u_sequencer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    gdfs_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .start        (start),
        .mode         (mode),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .flags        (flags),
        .result_valid (result_valid),
        .kind         (kind),
        .status       (status),
        .vertex       (vertex),
        .order_number (order_number),
        .last         (last)
    );

endmodule

[design/gdfs_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on gdfs_pkg for the control word, step and flag types.
`timescale 1ns / 1ps

module gdfs_sequencer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  gdfs_pkg::dp_flags_t    flags,
    output gdfs_pkg::ctrl_word_t   ctrl,
    output logic                   busy
);

    gdfs_pkg::step_t pc_reg;
    gdfs_pkg::step_t pc_next;
    logic            taken;

    always_comb
    begin
        case (ctrl.cond)
            gdfs_pkg::C_ALWAYS:       taken = 1'b1;
            gdfs_pkg::C_NO_START:     taken = !flags.start;
            gdfs_pkg::C_MODE_RUN:     taken = flags.mode_run;
            gdfs_pkg::C_INS_BAD:      taken = flags.ins_bad;
            gdfs_pkg::C_EDGE_PRESENT: taken = flags.edge_present;
            gdfs_pkg::C_ROOT_END:     taken = flags.root_end;
            gdfs_pkg::C_ROOT_SEEN:    taken = flags.root_seen;
            gdfs_pkg::C_CAND_NZ:      taken = flags.cand_nz;
            gdfs_pkg::C_LAST_POP:     taken = flags.last_pop;
            gdfs_pkg::C_EMIT_MORE:    taken = flags.emit_more;
            default:                  taken = 1'b1;
        endcase
    end

    always_comb
    begin
        if (taken)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = gdfs_pkg::step_t'(5'(pc_reg) + 5'd1);
        end
    end

    always_comb
    begin
        ctrl = gdfs_pkg::ucode_rom(pc_reg);
        busy = (pc_reg != gdfs_pkg::S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= gdfs_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[design/gdfs_datapath.sv]
// Datapath of the preorder core: adjacency matrix, visited marks, walk stack,
// preorder store, counters and result registers, all driven by the control word.
// Depends on gdfs_pkg for widths, codes and the control and flag types.
`timescale 1ns / 1ps

module gdfs_datapath
#(
    parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  gdfs_pkg::ctrl_word_t              ctrl,
    input  logic                              start,
    input  logic                              mode,
    input  logic [gdfs_pkg::VERTEX_W-1:0]     vertex_a,
    input  logic [gdfs_pkg::VERTEX_W-1:0]     vertex_b,
    input  logic                              cfg_we,
    input  logic [gdfs_pkg::CFG_W-1:0]        cfg_data,
    output gdfs_pkg::dp_flags_t               flags,
    output logic                              result_valid,
    output logic                              kind,
    output logic [gdfs_pkg::STATUS_W-1:0]     status,
    output logic [gdfs_pkg::VERTEX_W-1:0]     vertex,
    output logic [gdfs_pkg::ORDER_W-1:0]      order_number,
    output logic                              last
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = AW + 1;

    logic [gdfs_pkg::CFG_W-1:0]    vertex_count_reg;
    logic [gdfs_pkg::CFG_W-1:0]    vertex_count_next;
    logic [CNT_W-1:0]              n_eff;
    logic [CNT_W-1:0]              last_idx;
    logic [MAX_VERTICES-1:0]       mask;

    logic                          mode_reg,   mode_next;
    logic [gdfs_pkg::VERTEX_W-1:0] a_reg,      a_next;
    logic [gdfs_pkg::VERTEX_W-1:0] b_reg,      b_next;
    logic [gdfs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [MAX_VERTICES-1:0]       visited_reg, visited_next;
    logic [CNT_W-1:0]              root_reg,   root_next;
    logic [CNT_W-1:0]              sp_reg,     sp_next;
    logic [CNT_W-1:0]              order_reg,  order_next;
    logic [AW-1:0]                 idx_reg,    idx_next;

    logic                          res_valid_reg, res_valid_next;
    logic                          kind_reg,      kind_next;
    logic [gdfs_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [gdfs_pkg::VERTEX_W-1:0] vertex_reg,    vertex_next;
    logic [gdfs_pkg::ORDER_W-1:0]  order_out_reg, order_out_next;
    logic                          last_reg,      last_next;

    logic [MAX_VERTICES-1:0]       adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]       adj_valid_reg, adj_valid_next;
    logic [MAX_VERTICES-1:0]       adj_q_reg;
    logic                          adj_ok_reg;
    logic [MAX_VERTICES-1:0]       adj_row;
    logic [AW-1:0]                 adj_raddr;
    logic                          adj_we;
    logic [AW-1:0]                 adj_waddr;
    logic [MAX_VERTICES-1:0]       adj_wdata;

    logic [AW-1:0]                 pre_mem [MAX_VERTICES];
    logic [AW-1:0]                 pre_q_reg;
    logic [AW-1:0]                 pre_raddr;
    logic [AW-1:0]                 stk_mem [MAX_VERTICES];
    logic [AW-1:0]                 stk_q_reg;
    logic [AW-1:0]                 stk_raddr;

    logic                          a_out, b_out, self_loop, ins_bad;
    logic [AW-1:0]                 a_idx, b_idx, root_idx;
    logic [MAX_VERTICES-1:0]       onehot_a, onehot_b;
    logic [MAX_VERTICES-1:0]       cand;
    logic [AW-1:0]                 pe;
    logic                          visit;
    logic [AW-1:0]                 v_sel;
    logic                          at_last;

    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (vertex_count_reg > gdfs_pkg::CFG_W'(MAX_VERTICES))
        begin
            n_eff = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CNT_W'(vertex_count_reg);
        end
        last_idx = n_eff - CNT_W'(1);
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            mask[i] = (CNT_W'(i) < n_eff);
        end
    end

    always_comb
    begin
        a_out     = (gdfs_pkg::CFG_W'(a_reg) >= gdfs_pkg::CFG_W'(n_eff));
        b_out     = (gdfs_pkg::CFG_W'(b_reg) >= gdfs_pkg::CFG_W'(n_eff));
        self_loop = (a_reg == b_reg);
        ins_bad   = a_out || b_out || self_loop;
        a_idx     = a_reg[AW-1:0];
        b_idx     = b_reg[AW-1:0];
        root_idx  = root_reg[AW-1:0];
        onehot_a  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx;
        onehot_b  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_idx;
        adj_row   = adj_ok_reg ? adj_q_reg : '0;
        cand      = adj_row & mask & ~visited_reg;
        at_last   = ({1'b0, idx_reg} == last_idx);
        stk_raddr = AW'(sp_reg - CNT_W'(2));
    end

    always_comb
    begin
        pe = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pe = AW'(i);
            end
        end
    end

    always_comb
    begin
        flags.start        = start;
        flags.mode_run     = mode_reg;
        flags.ins_bad      = ins_bad;
        flags.edge_present = adj_row[b_idx];
        flags.root_end     = (root_reg >= n_eff);
        flags.root_seen    = visited_reg[root_idx];
        flags.cand_nz      = |cand;
        flags.last_pop     = (sp_reg == CNT_W'(1));
        flags.emit_more    = !at_last;
    end

    always_comb
    begin
        vertex_count_next = cfg_we ? cfg_data : vertex_count_reg;
        mode_next         = mode_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        status_next       = status_reg;
        visited_next      = visited_reg;
        root_next         = root_reg;
        sp_next           = sp_reg;
        order_next        = order_reg;
        idx_next          = idx_reg;
        res_valid_next    = 1'b0;
        kind_next         = kind_reg;
        res_status_next   = res_status_reg;
        vertex_next       = vertex_reg;
        order_out_next    = order_out_reg;
        last_next         = last_reg;
        adj_raddr         = a_idx;
        adj_we            = 1'b0;
        adj_waddr         = a_idx;
        adj_wdata         = adj_row | onehot_b;
        pre_raddr         = '0;
        visit             = 1'b0;
        v_sel             = root_idx;

        case (ctrl.op)
            gdfs_pkg::OP_LATCH:
            begin
                if (start)
                begin
                    mode_next = mode;
                    a_next    = vertex_a;
                    b_next    = vertex_b;
                end
            end
            gdfs_pkg::OP_INS_CHECK:
            begin
                adj_raddr = a_idx;
                if (a_out || b_out)
                begin
                    status_next = gdfs_pkg::ST_RANGE;
                end
                else if (self_loop)
                begin
                    status_next = gdfs_pkg::ST_SELF_LOOP;
                end
                else
                begin
                    status_next = gdfs_pkg::ST_ADDED;
                end
            end
            gdfs_pkg::OP_INS_TEST:
            begin
                adj_raddr = b_idx;
                if (adj_row[b_idx])
                begin
                    status_next = gdfs_pkg::ST_PRESENT;
                end
                else
                begin
                    adj_we    = 1'b1;
                    adj_waddr = a_idx;
                    adj_wdata = adj_row | onehot_b;
                end
            end
            gdfs_pkg::OP_INS_SET_B:
            begin
                adj_we    = 1'b1;
                adj_waddr = b_idx;
                adj_wdata = adj_row | onehot_a;
            end
            gdfs_pkg::OP_EMIT_STATUS:
            begin
                res_valid_next  = 1'b1;
                kind_next       = gdfs_pkg::KIND_STATUS;
                res_status_next = status_reg;
                vertex_next     = '0;
                order_out_next  = '0;
                last_next       = 1'b0;
            end
            gdfs_pkg::OP_RUN_CLEAR:
            begin
                visited_next = '0;
                root_next    = '0;
                sp_next      = '0;
                order_next   = '0;
            end
            gdfs_pkg::OP_VISIT_ROOT:
            begin
                visit     = 1'b1;
                v_sel     = root_idx;
                adj_raddr = root_idx;
            end
            gdfs_pkg::OP_SCAN:
            begin
                adj_raddr = pe;
                if (|cand)
                begin
                    visit = 1'b1;
                    v_sel = pe;
                end
            end
            gdfs_pkg::OP_POP:
            begin
                sp_next = sp_reg - CNT_W'(1);
            end
            gdfs_pkg::OP_TOP_LOAD:
            begin
                adj_raddr = stk_q_reg;
            end
            gdfs_pkg::OP_ROOT_INC:
            begin
                root_next = root_reg + CNT_W'(1);
            end
            gdfs_pkg::OP_EMIT_INIT:
            begin
                idx_next  = '0;
                pre_raddr = '0;
            end
            gdfs_pkg::OP_EMIT_ENTRY:
            begin
                res_valid_next  = 1'b1;
                kind_next       = gdfs_pkg::KIND_ENTRY;
                res_status_next = gdfs_pkg::ST_ADDED;
                vertex_next     = gdfs_pkg::VERTEX_W'(idx_reg);
                order_out_next  = gdfs_pkg::ORDER_W'(pre_q_reg);
                last_next       = at_last;
                idx_next        = idx_reg + AW'(1);
                pre_raddr       = idx_reg + AW'(1);
            end
            default:
            begin
            end
        endcase

        if (visit)
        begin
            order_next   = order_reg + CNT_W'(1);
            sp_next      = sp_reg + CNT_W'(1);
            visited_next = visited_reg | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << v_sel);
        end

        adj_valid_next = adj_valid_reg;
        if (adj_we)
        begin
            adj_valid_next[adj_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= gdfs_pkg::VERTEX_COUNT_RST;
            mode_reg         <= 1'b0;
            status_reg       <= gdfs_pkg::ST_ADDED;
            visited_reg      <= '0;
            root_reg         <= '0;
            sp_reg           <= '0;
            order_reg        <= '0;
            idx_reg          <= '0;
            res_valid_reg    <= 1'b0;
            adj_valid_reg    <= '0;
            adj_ok_reg       <= 1'b0;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
            mode_reg         <= mode_next;
            status_reg       <= status_next;
            visited_reg      <= visited_next;
            root_reg         <= root_next;
            sp_reg           <= sp_next;
            order_reg        <= order_next;
            idx_reg          <= idx_next;
            res_valid_reg    <= res_valid_next;
            adj_valid_reg    <= adj_valid_next;
            adj_ok_reg       <= adj_valid_reg[adj_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        kind_reg       <= kind_next;
        res_status_reg <= res_status_next;
        vertex_reg     <= vertex_next;
        order_out_reg  <= order_out_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_q_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (visit)
        begin
            pre_mem[v_sel] <= order_reg[AW-1:0];
        end
        pre_q_reg <= pre_mem[pre_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (visit)
        begin
            stk_mem[sp_reg[AW-1:0]] <= v_sel;
        end
        stk_q_reg <= stk_mem[stk_raddr];
    end

    assign result_valid = res_valid_reg;
    assign kind         = kind_reg;
    assign status       = res_status_reg;
    assign vertex       = vertex_reg;
    assign order_number = order_out_reg;
    assign last         = last_reg;

endmodule
